[sv/bfs_pkg.sv]
package bfs_pkg;

    localparam int MAX_ENTRIES = 256;

    localparam int C_ADDR_W    = $clog2(MAX_ENTRIES);
    localparam int C_CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int C_CFG_W     = 9;
    localparam int C_CFG_IDX_W = 1;
    localparam int C_BYTE_W    = 8;
    localparam int C_CMP_W     = (C_CNT_W > C_CFG_W) ? C_CNT_W : C_CFG_W;
    localparam int C_SUM_W     = ((C_CNT_W > C_BYTE_W) ? C_CNT_W : C_BYTE_W) + 1;

    localparam int C_DEPTH_RST = (16 > MAX_ENTRIES) ? MAX_ENTRIES : 16;
    localparam int C_LEVEL_RST = 12;

    localparam logic [C_BYTE_W-1:0] C_EMPTY_BYTE = 8'hFF;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_PUSH  = 3'd1,
        KIND_POP   = 3'd2,
        KIND_CLEAR = 3'd3,
        KIND_PEEK  = 3'd4
    } t_kind;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_FIFO_DEPTH  = 1'd0,
        CFG_ALMOST_FULL = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]          kind;
        logic [C_BYTE_W-1:0] push_byte;
        logic [C_BYTE_W-1:0] peek_offset;
        logic                clear_overflow;
        logic                clear_underflow;
    } t_req;

    typedef struct packed {
        logic [C_BYTE_W-1:0] read_byte;
        logic                accepted;
        logic [8:0]          entry_count;
        logic                is_empty;
        logic                is_full;
        logic                almost_full;
        logic                overflow_seen;
        logic                underflow_seen;
    } t_rsp;

    typedef struct packed {
        logic                we;
        logic [C_ADDR_W-1:0] waddr;
        logic [C_BYTE_W-1:0] wdata;
        logic                re;
        logic [C_ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

[sv/bfs_mem.sv]
module bfs_mem import bfs_pkg::*; (
    input  logic                i_clk,
    input  t_mem_req            i_mem_req,
    output logic [C_BYTE_W-1:0] o_mem_q
);

    logic [C_BYTE_W-1:0] r_mem [MAX_ENTRIES];
    logic [C_BYTE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_mem_req.we) begin
            r_mem[i_mem_req.waddr] <= i_mem_req.wdata;
        end
        if (i_mem_req.re) begin
            r_q <= r_mem[i_mem_req.raddr];
        end
    end

    assign o_mem_q = r_q;

endmodule

[sv/bfs_ctrl.sv]
module bfs_ctrl import bfs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [C_CFG_W-1:0]     i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_req                   i_in_req,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_rsp                   o_out_rsp,
    output t_mem_req               o_mem_req,
    input  logic [C_BYTE_W-1:0]    i_mem_q
);

    logic [C_CNT_W-1:0]  r_depth;
    logic [C_CFG_W-1:0]  r_level;
    logic [C_ADDR_W-1:0] r_rp;
    logic [C_ADDR_W-1:0] r_wp;
    logic [C_CNT_W-1:0]  r_cnt;
    logic                r_ovf;
    logic                r_unf;
    logic                r_out_valid;
    t_rsp                r_rsp;
    logic                r_use_mem;

    logic [C_ADDR_W-1:0] n_rp;
    logic [C_ADDR_W-1:0] n_wp;
    logic [C_CNT_W-1:0]  n_cnt;
    logic                n_ovf;
    logic                n_unf;
    t_rsp                n_rsp;
    logic                n_use_mem;

    logic                w_accept;
    logic                w_ovf_evt;
    logic                w_unf_evt;
    logic                w_we;
    logic                w_re;
    logic [C_ADDR_W-1:0] w_raddr;
    logic [C_CNT_W-1:0]  w_rp_inc;
    logic [C_CNT_W-1:0]  w_wp_inc;
    logic [C_ADDR_W-1:0] w_rp_adv;
    logic [C_ADDR_W-1:0] w_wp_adv;
    logic [C_SUM_W-1:0]  w_peek_sum;
    logic [C_ADDR_W-1:0] w_peek_addr;
    logic                w_peek_ok;
    logic                w_full_now;
    logic [C_CNT_W-1:0]  w_depth_clamp;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // pointer wrap at the configured depth
    assign w_rp_inc = C_CNT_W'(r_rp) + 1'b1;
    assign w_wp_inc = C_CNT_W'(r_wp) + 1'b1;
    assign w_rp_adv = (w_rp_inc >= r_depth) ? '0 : w_rp_inc[C_ADDR_W-1:0];
    assign w_wp_adv = (w_wp_inc >= r_depth) ? '0 : w_wp_inc[C_ADDR_W-1:0];

    assign w_peek_sum  = C_SUM_W'(r_rp) + C_SUM_W'(i_in_req.peek_offset);
    assign w_peek_addr = (w_peek_sum >= C_SUM_W'(r_depth)) ?
                         C_ADDR_W'(w_peek_sum - C_SUM_W'(r_depth)) :
                         C_ADDR_W'(w_peek_sum);
    assign w_peek_ok   = C_SUM_W'(i_in_req.peek_offset) < C_SUM_W'(r_cnt);
    assign w_full_now  = r_cnt >= r_depth;

    always_comb begin
        if (i_cfg_data == '0) begin
            w_depth_clamp = C_CNT_W'(1);
        end else if (C_CMP_W'(i_cfg_data) > C_CMP_W'(MAX_ENTRIES)) begin
            w_depth_clamp = C_CNT_W'(MAX_ENTRIES);
        end else begin
            w_depth_clamp = C_CNT_W'(i_cfg_data);
        end
    end

    always_comb begin
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_cnt     = r_cnt;
        w_ovf_evt = r_ovf;
        w_unf_evt = r_unf;
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_raddr   = r_rp;
        n_use_mem = 1'b0;
        n_rsp     = '0;
        unique case (i_in_req.kind)
            KIND_PUSH: begin
                if (w_full_now) begin
                    w_ovf_evt = 1'b1;
                end else begin
                    w_we           = 1'b1;
                    n_wp           = w_wp_adv;
                    n_cnt          = r_cnt + 1'b1;
                    n_rsp.accepted = 1'b1;
                end
            end
            KIND_POP: begin
                if (r_cnt == '0) begin
                    w_unf_evt       = 1'b1;
                    n_rsp.read_byte = C_EMPTY_BYTE;
                end else begin
                    w_re           = 1'b1;
                    n_use_mem      = 1'b1;
                    n_rp           = w_rp_adv;
                    n_cnt          = r_cnt - 1'b1;
                    n_rsp.accepted = 1'b1;
                end
            end
            KIND_CLEAR: begin
                n_rp  = '0;
                n_wp  = '0;
                n_cnt = '0;
            end
            KIND_PEEK: begin
                if (w_peek_ok) begin
                    w_re           = 1'b1;
                    w_raddr        = w_peek_addr;
                    n_use_mem      = 1'b1;
                    n_rsp.accepted = 1'b1;
                end else begin
                    n_rsp.read_byte = C_EMPTY_BYTE;
                end
            end
            default: begin
            end
        endcase
        n_rsp.entry_count    = 9'(n_cnt);
        n_rsp.is_empty       = (n_cnt == '0);
        n_rsp.is_full        = (n_cnt >= r_depth);
        n_rsp.almost_full    = (C_CMP_W'(n_cnt) >= C_CMP_W'(r_level));
        n_rsp.overflow_seen  = w_ovf_evt;
        n_rsp.underflow_seen = w_unf_evt;
        // flags are reported first, then cleared on request
        n_ovf = w_ovf_evt && !i_in_req.clear_overflow;
        n_unf = w_unf_evt && !i_in_req.clear_underflow;
    end

    assign o_mem_req.we    = w_we && w_accept;
    assign o_mem_req.waddr = r_wp;
    assign o_mem_req.wdata = i_in_req.push_byte;
    assign o_mem_req.re    = w_re && w_accept;
    assign o_mem_req.raddr = w_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= C_CNT_W'(C_DEPTH_RST);
            r_level     <= C_CFG_W'(C_LEVEL_RST);
            r_rp        <= '0;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_unf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_use_mem   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIFO_DEPTH: begin
                    r_depth <= w_depth_clamp;
                    r_rp    <= '0;
                    r_wp    <= '0;
                    r_cnt   <= '0;
                    r_ovf   <= 1'b0;
                    r_unf   <= 1'b0;
                end
                CFG_ALMOST_FULL: begin
                    r_level <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end else if (w_accept) begin
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_unf       <= n_unf;
            r_out_valid <= 1'b1;
            r_use_mem   <= n_use_mem;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    always_comb begin
        o_out_rsp = r_rsp;
        if (r_use_mem) begin
            o_out_rsp.read_byte = i_mem_q;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/byte_fifo_with_status.sv]
// Byte FIFO with status. Each request (none, push, pop, clear or peek) is taken
// and its response appears in the output register on the next cycle, so the
// block sustains one request per clock; a request is taken in the same cycle
// that the previous response leaves, but no request is taken while that
// response waits under stall. The response comes from the response register
// and the registered read port of the byte memory (one write and one read
// port). Every response carries the count, empty, full, almost-full and the
// sticky overflow and underflow flags as they stand after the request; a
// requested flag clear acts after that report. Writing the depth register
// empties the FIFO and clears both flags; depth 0 acts as 1 and larger values
// are held to the built maximum. Configuration is to be written by the user
// only while the block is idle; the block itself does not enforce this.
module byte_fifo_with_status import bfs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [C_CFG_W-1:0]     i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_req                   i_in_req,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_rsp                   o_out_rsp
);

    t_mem_req            w_mem_req;
    logic [C_BYTE_W-1:0] w_mem_q;

    bfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .o_mem_req   (w_mem_req),
        .i_mem_q     (w_mem_q)
    );

    bfs_mem u_mem (
        .i_clk     (i_clk),
        .i_mem_req (w_mem_req),
        .o_mem_q   (w_mem_q)
    );

endmodule

[sv/bfs_checker.sv]
module bfs_checker import bfs_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input t_rsp                   o_out_rsp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("response dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_rsp))
        else $error("response changed under stall");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.is_empty == (o_out_rsp.entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.is_empty) |-> !o_out_rsp.is_full)
        else $error("empty and full together");

    a_stall_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with output free");

endmodule

bind byte_fifo_with_status bfs_checker u_bfs_checker (.*);

[tb/fifo_status_checker.sv]
module fifo_status_checker import bfs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [C_CFG_W-1:0]     i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_req                   i_in_req,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_rsp                   i_out_rsp,
    output int                     o_pending,
    output int                     o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [C_BYTE_W-1:0] model_bytes [MAX_ENTRIES];
    int                  head_ptr;
    int                  tail_ptr;
    int                  held;
    logic                ovf_flag;
    logic                unf_flag;
    logic [C_CFG_W-1:0]  depth_cfg;
    logic [C_CFG_W-1:0]  level_cfg;
    t_rsp                expected_rsp_q [$];

    function automatic int next_slot(int p, int d);
        return (p + 1 >= d) ? 0 : p + 1;
    endfunction

    task automatic empty_model();
        head_ptr = 0;
        tail_ptr = 0;
        held     = 0;
        ovf_flag = 1'b0;
        unf_flag = 1'b0;
    endtask

    function automatic t_rsp predict_fifo_rsp(t_req r);
        t_rsp e;
        int   d;
        int   a;
        if (depth_cfg == 0) begin
            d = 1;
        end else if (int'(depth_cfg) > MAX_ENTRIES) begin
            d = MAX_ENTRIES;
        end else begin
            d = int'(depth_cfg);
        end
        e = '0;
        case (r.kind)
            KIND_PUSH: begin
                if (held >= d) begin
                    ovf_flag = 1'b1;
                end else begin
                    model_bytes[tail_ptr] = r.push_byte;
                    tail_ptr = next_slot(tail_ptr, d);
                    held++;
                    e.accepted = 1'b1;
                end
            end
            KIND_POP: begin
                if (held == 0) begin
                    unf_flag    = 1'b1;
                    e.read_byte = C_EMPTY_BYTE;
                end else begin
                    e.read_byte = model_bytes[head_ptr];
                    head_ptr = next_slot(head_ptr, d);
                    held--;
                    e.accepted = 1'b1;
                end
            end
            KIND_CLEAR: begin
                head_ptr = 0;
                tail_ptr = 0;
                held     = 0;
            end
            KIND_PEEK: begin
                if (int'(r.peek_offset) >= held) begin
                    e.read_byte = C_EMPTY_BYTE;
                end else begin
                    a = head_ptr + int'(r.peek_offset);
                    if (a >= d) begin
                        a -= d;
                    end
                    e.read_byte = model_bytes[a];
                    e.accepted  = 1'b1;
                end
            end
            default: begin
            end
        endcase
        e.entry_count    = 9'(held);
        e.is_empty       = (held == 0);
        e.is_full        = (held >= d);
        e.almost_full    = (held >= int'(level_cfg));
        e.overflow_seen  = ovf_flag;
        e.underflow_seen = unf_flag;
        // flags are reported first, then cleared on request
        if (r.clear_overflow) begin
            ovf_flag = 1'b0;
        end
        if (r.clear_underflow) begin
            unf_flag = 1'b0;
        end
        return e;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            depth_cfg = C_CFG_W'(C_DEPTH_RST);
            level_cfg = C_CFG_W'(C_LEVEL_RST);
            empty_model();
            expected_rsp_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FIFO_DEPTH) begin
                    depth_cfg = i_cfg_data;
                    empty_model();
                end else if (i_cfg_index == CFG_ALMOST_FULL) begin
                    level_cfg = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_rsp_q.push_back(predict_fifo_rsp(i_in_req));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("response with no request pending");
                    o_fail_count++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("read_byte", want.read_byte, i_out_rsp.read_byte);
                    check_field("accepted", want.accepted, i_out_rsp.accepted);
                    check_field("entry_count", want.entry_count, i_out_rsp.entry_count);
                    check_field("is_empty", want.is_empty, i_out_rsp.is_empty);
                    check_field("is_full", want.is_full, i_out_rsp.is_full);
                    check_field("almost_full", want.almost_full, i_out_rsp.almost_full);
                    check_field("overflow_seen", want.overflow_seen,
                                i_out_rsp.overflow_seen);
                    check_field("underflow_seen", want.underflow_seen,
                                i_out_rsp.underflow_seen);
                end
            end
        end
        o_pending = expected_rsp_q.size();
    end

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfs_pkg::*;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam int         LONG_HOLD        = 400;
    localparam int         CYCLE_LIMIT      = 200000;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [C_CFG_IDX_W-1:0] cfg_index  = '0;
    logic [C_CFG_W-1:0]     cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    t_req                   in_req     = '0;
    logic                   out_stall  = 1'b0;
    logic                   in_stall;
    logic                   out_valid;
    t_rsp                   out_rsp;

    int pending;
    int fail_count;
    int cycle_count  = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    byte_fifo_with_status dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp)
    );

    fifo_status_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_rsp    (out_rsp),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // response side: random stall, or a long hold-off when asked for
    always @(posedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_req make_req(logic [2:0] kind, int data_val, int offset,
                                      bit clr_ovf, bit clr_unf);
        t_req r;
        r.kind            = kind;
        r.push_byte       = 8'(data_val);
        r.peek_offset     = 8'(offset);
        r.clear_overflow  = clr_ovf;
        r.clear_underflow = clr_unf;
        return r;
    endfunction

    function automatic t_req random_req(int push_pct);
        t_req r;
        int   sel;
        r.push_byte       = 8'($urandom);
        r.peek_offset     = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        r.clear_overflow  = ($urandom_range(7) == 0);
        r.clear_underflow = ($urandom_range(7) == 0);
        sel = $urandom_range(99);
        if (sel < 3) begin
            r.kind = KIND_NONE;
        end else if (sel < 5) begin
            r.kind = 3'($urandom_range(int'(KIND_SPARE_LAST), int'(KIND_SPARE_FIRST)));
        end else if (sel < 7) begin
            r.kind = KIND_CLEAR;
        end else if (sel < 22) begin
            r.kind = KIND_PEEK;
        end else if ($urandom_range(99) < push_pct) begin
            r.kind = KIND_PUSH;
        end else begin
            r.kind = KIND_POP;
        end
        return r;
    endfunction

    task automatic send_req(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= C_CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(int depth, int level, int idle, int stall, int push_pct,
                             int fill, int n);
        wait_drained();
        write_cfg(CFG_FIFO_DEPTH, depth);
        write_cfg(CFG_ALMOST_FULL, level);
        idle_pct = idle;
        stall_pct <= stall;
        repeat (fill) send_req(make_req(KIND_PUSH, $urandom, 0, 1'b0, 1'b0));
        repeat (n) send_req(random_req(push_pct));
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: depth 16, level 12
        send_req(make_req(KIND_POP, 0, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PEEK, 0, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PUSH, 8'h00, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PUSH, 8'hFF, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PEEK, 0, 1, 1'b0, 1'b0));
        send_req(make_req(KIND_PEEK, 0, 2, 1'b0, 1'b0));
        send_req(make_req(KIND_PEEK, 0, 255, 1'b0, 1'b0));
        send_req(make_req(KIND_POP, 0, 0, 1'b0, 1'b1));
        for (int k = int'(KIND_SPARE_FIRST); k <= int'(KIND_SPARE_LAST); k++) begin
            send_req(make_req(3'(k), 8'hFF, 8'hFF, 1'b0, 1'b0));
        end
        send_req(make_req(KIND_CLEAR, 0, 0, 1'b0, 1'b0));

        // tiny fifo: fill, overflow, wrap
        wait_drained();
        write_cfg(CFG_FIFO_DEPTH, 2);
        write_cfg(CFG_ALMOST_FULL, 1);
        send_req(make_req(KIND_PUSH, 8'h5A, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PUSH, 8'hC3, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PUSH, 8'h11, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PEEK, 0, 1, 1'b0, 1'b0));
        send_req(make_req(KIND_POP, 0, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PUSH, 8'h77, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PEEK, 0, 1, 1'b0, 1'b0));
        send_req(make_req(KIND_NONE, 0, 0, 1'b1, 1'b0));
        send_req(make_req(KIND_PUSH, 8'h22, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_CLEAR, 0, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_POP, 0, 0, 1'b1, 1'b0));

        // depth zero acts as one; the write also clears the flags
        wait_drained();
        write_cfg(CFG_FIFO_DEPTH, 0);
        send_req(make_req(KIND_PUSH, 8'h3C, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_PUSH, 8'h96, 0, 1'b0, 1'b0));
        send_req(make_req(KIND_POP, 0, 0, 1'b1, 1'b1));

        run_phase(16, 12, 0, 0, 55, 0, 150);
        // long hold-off on the response side while requests keep coming
        hold_trigger <= hold_trigger + 1;
        repeat (80) send_req(random_req(70));

        run_phase(1, 0, 54, 0, 50, 0, 150);
        run_phase(300, 256, 0, 54, 50, 260, 150);
        run_phase(7, 5, 35, 35, 60, 0, 100);
        wait_drained();
        repeat (100) send_req(random_req(60));
        run_phase(511, 511, 0, 0, 65, 0, 150);
        run_phase(0, 1, 35, 35, 50, 0, 100);
        run_phase($urandom_range(40, 2), $urandom_range(40, 0), 54, 54, 55, 0, 100);
        run_phase($urandom_range(40, 2), $urandom_range(40, 0), 35, 35, 55, 0, 100);

        wait_drained();
        repeat (5) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
